// ===== rtl/core/pfe_pkg.sv =====
// Shared types, constants and helpers for the Playfair stream encipherer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package pfe_pkg;

   localparam int LETTER_W  = 5;
   localparam int ROW_W     = 25;
   localparam int NUM_ROWS  = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

   localparam logic [7:0] ASCII_UP_A = 8'h41;
   localparam logic [7:0] ASCII_UP_Z = 8'h5A;
   localparam logic [7:0] ASCII_LO_A = 8'h61;
   localparam logic [7:0] ASCII_LO_Z = 8'h7A;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW4 = 3'd4;

   localparam logic [ROW_W-1:0] KEY_ROW0_RST = 25'd10755244;
   localparam logic [ROW_W-1:0] KEY_ROW1_RST = 25'd17283508;
   localparam logic [ROW_W-1:0] KEY_ROW2_RST = 25'd25942713;
   localparam logic [ROW_W-1:0] KEY_ROW3_RST = 25'd6848868;
   localparam logic [ROW_W-1:0] KEY_ROW4_RST = 25'd2149955;

   typedef logic [ROW_W-1:0] key_row_type;
   typedef key_row_type [NUM_ROWS-1:0] key_square_type;

   // one digraph (or an empty end marker) queued for the back end
   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
      logic                empty;
   } job_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } pos_type;

   function automatic logic [LETTER_W-1:0] cell_at(input key_square_type sq,
                                                   input logic [2:0] row,
                                                   input logic [2:0] col);
      return sq[row][LETTER_W*col +: LETTER_W];
   endfunction

   function automatic logic [2:0] step5(input logic [2:0] idx);
      return (idx == 3'd4) ? 3'd0 : idx + 3'd1;
   endfunction

   // first match in row-major order; no match gives row 0, column 0
   function automatic pos_type locate(input logic [LETTER_W-1:0] code,
                                      input key_square_type sq);
      logic [LETTER_W-1:0] key;
      pos_type             pos;
      key = (code == CODE_J) ? CODE_I : code;
      pos = '0;
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
         for (int c = 4; c >= 0; c--) begin
            if (sq[r][LETTER_W*c +: LETTER_W] == key) begin
               pos.row = 3'(r);
               pos.col = 3'(c);
            end
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/playfair_stream_encrypt.sv =====
// Top level of the Playfair stream encipherer: key square registers, front
// end, job queue and back end. Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back.
//
//   channel   dir  handshake              payload
//   req_*     in   req_tvalid/req_tready  tdata[7:0] plaintext byte, tlast end of message
//   rsp_*     out  rsp_tvalid/rsp_tready  tdata[7:0] cipher letter, tuser empty, tlast
//   csr_*     in   csr_we                 csr_addr row index, csr_wdata[24:0] key row
//
// One request per cycle is taken while the queue has room; a request that
// yields two digraphs holds req_tready low until its second digraph is queued.
// Each digraph leaves the output register as two response letters, an empty
// end marker as one; the locate stage can take the next job meanwhile.
// Reset is synchronous and loads the default key square.
// Either side may stall; the queue absorbs up to QUEUE_DEPTH jobs.
`default_nettype none

module playfair_stream_encrypt #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_char
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_letter
   output logic             rsp_tuser,   // [0] out_empty
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [24:0] csr_wdata
);
   import pfe_pkg::*;

   key_square_type key_sq_ff;
   logic           push, q_full, q_nonempty, pop;
   job_type        push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_sq_ff[0] <= KEY_ROW0_RST;
         key_sq_ff[1] <= KEY_ROW1_RST;
         key_sq_ff[2] <= KEY_ROW2_RST;
         key_sq_ff[3] <= KEY_ROW3_RST;
         key_sq_ff[4] <= KEY_ROW4_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KEY_ROW0: key_sq_ff[0] <= csr_wdata;
            CSR_KEY_ROW1: key_sq_ff[1] <= csr_wdata;
            CSR_KEY_ROW2: key_sq_ff[2] <= csr_wdata;
            CSR_KEY_ROW3: key_sq_ff[3] <= csr_wdata;
            CSR_KEY_ROW4: key_sq_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   pfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head_job (head_job),
      .nonempty (q_nonempty)
   );

   pfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .key_sq     (key_sq_ff),
      .q_nonempty (q_nonempty),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pfe_front.sv =====
// Front end: filters and folds request bytes, pairs letters into digraph jobs.
// Depends on pfe_pkg; feeds pfe_queue.
`default_nettype none

module pfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,
   input  wire logic            req_tlast,
   output logic                 push,
   output pfe_pkg::job_type     push_job,
   input  wire logic            q_full
);
   import pfe_pkg::*;

   logic [LETTER_W-1:0] pend_letter_ff, pend_letter_in;
   logic                pend_valid_ff, pend_valid_in;
   job_type             extra_job_ff, extra_job_in;
   logic                extra_valid_ff, extra_valid_in;

   logic                accept;
   logic                is_upper, is_lower, have;
   logic [LETTER_W-1:0] code;
   job_type             job1, job2;
   logic                job1_valid, job2_valid;

   assign is_upper   = (req_tdata >= ASCII_UP_A) && (req_tdata <= ASCII_UP_Z);
   assign is_lower   = (req_tdata >= ASCII_LO_A) && (req_tdata <= ASCII_LO_Z);
   assign have       = is_upper || is_lower;
   assign req_tready = !extra_valid_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      code           = is_lower ? LETTER_W'(req_tdata - ASCII_LO_A)
                                : LETTER_W'(req_tdata - ASCII_UP_A);
      job1           = '0;
      job2           = '0;
      job1_valid     = 1'b0;
      job2_valid     = 1'b0;
      pend_letter_in = pend_letter_ff;
      pend_valid_in  = pend_valid_ff;
      if (have && !pend_valid_ff) begin
         if (req_tlast) begin
            job1       = '{first: code, second: CODE_X, last: 1'b1, empty: 1'b0};
            job1_valid = 1'b1;
         end else begin
            pend_letter_in = code;
            pend_valid_in  = 1'b1;
         end
      end else if (have && pend_letter_ff == code) begin
         job1       = '{first: pend_letter_ff, second: CODE_X, last: 1'b0, empty: 1'b0};
         job1_valid = 1'b1;
         if (req_tlast) begin
            job2       = '{first: code, second: CODE_X, last: 1'b1, empty: 1'b0};
            job2_valid = 1'b1;
         end else begin
            pend_letter_in = code;
         end
      end else if (have) begin
         job1          = '{first: pend_letter_ff, second: code, last: req_tlast, empty: 1'b0};
         job1_valid    = 1'b1;
         pend_valid_in = 1'b0;
      end else if (req_tlast) begin
         job1_valid = 1'b1;
         if (pend_valid_ff) begin
            job1 = '{first: pend_letter_ff, second: CODE_X, last: 1'b1, empty: 1'b0};
         end else begin
            job1 = '{first: '0, second: '0, last: 1'b1, empty: 1'b1};
         end
      end
      if (req_tlast) begin
         pend_letter_in = '0;
         pend_valid_in  = 1'b0;
      end
   end

   always_comb begin
      extra_job_in   = extra_job_ff;
      extra_valid_in = extra_valid_ff;
      if (extra_valid_ff) begin
         push     = !q_full;
         push_job = extra_job_ff;
         if (!q_full) begin
            extra_valid_in = 1'b0;
         end
      end else begin
         push     = accept && job1_valid;
         push_job = job1;
         if (accept && job2_valid) begin
            extra_job_in   = job2;
            extra_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_letter_ff <= '0;
         pend_valid_ff  <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_letter_ff <= pend_letter_in;
            pend_valid_ff  <= pend_valid_in;
         end
         extra_valid_ff <= extra_valid_in;
      end
      extra_job_ff <= extra_job_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/pfe_queue.sv =====
// Short job queue between the front and back ends.
// Depends on pfe_pkg for the job type.
`default_nettype none

module pfe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pfe_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output pfe_pkg::job_type      head_job,
   output logic                  nonempty
);
   import pfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pfe_back.sv =====
// Back end: locates digraph letters in the key square, applies the cipher
// rules and streams two response letters per job, or one empty response for an end marker. Depends on pfe_pkg.
`default_nettype none

module pfe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pfe_pkg::key_square_type key_sq,
   input  wire logic             q_nonempty,
   input  wire pfe_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import pfe_pkg::*;

   // locate stage
   logic                loc_valid_ff;
   logic                loc_last_ff, loc_empty_ff;
   pos_type             loc_p1_ff, loc_p2_ff;
   pos_type             p1_in, p2_in;

   // output stage
   logic                out_valid_ff;
   logic                out_phase_ff;
   logic [LETTER_W-1:0] out_x_ff, out_y_ff;
   logic                out_last_ff, out_empty_ff;
   logic [LETTER_W-1:0] x_in, y_in;

   logic                out_done, out_free, load_out, loc_free;
   logic [LETTER_W-1:0] cur_code;

   assign out_done = out_valid_ff && rsp_tready && (out_phase_ff || out_empty_ff);
   assign out_free = !out_valid_ff || out_done;
   assign load_out = loc_valid_ff && out_free;
   assign loc_free = !loc_valid_ff || load_out;
   assign pop      = q_nonempty && loc_free;

   assign p1_in = locate(head_job.first, key_sq);
   assign p2_in = locate(head_job.second, key_sq);

   always_comb begin
      if (loc_p1_ff.row == loc_p2_ff.row) begin
         x_in = cell_at(key_sq, loc_p1_ff.row, step5(loc_p1_ff.col));
         y_in = cell_at(key_sq, loc_p2_ff.row, step5(loc_p2_ff.col));
      end else if (loc_p1_ff.col == loc_p2_ff.col) begin
         x_in = cell_at(key_sq, step5(loc_p1_ff.row), loc_p1_ff.col);
         y_in = cell_at(key_sq, step5(loc_p2_ff.row), loc_p2_ff.col);
      end else begin
         x_in = cell_at(key_sq, loc_p1_ff.row, loc_p2_ff.col);
         y_in = cell_at(key_sq, loc_p2_ff.row, loc_p1_ff.col);
      end
   end

   assign cur_code   = out_phase_ff ? out_y_ff : out_x_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_empty_ff ? 8'h00 : ASCII_UP_A + {3'b000, cur_code};
   assign rsp_tuser  = out_empty_ff;
   assign rsp_tlast  = out_last_ff && (out_phase_ff || out_empty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
      end else begin
         if (pop) begin
            loc_valid_ff <= 1'b1;
         end else if (load_out) begin
            loc_valid_ff <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
            out_phase_ff <= 1'b0;
         end else if (out_done) begin
            out_valid_ff <= 1'b0;
            out_phase_ff <= 1'b0;
         end else if (out_valid_ff && rsp_tready) begin
            out_phase_ff <= 1'b1;
         end
      end
      if (pop) begin
         loc_p1_ff    <= p1_in;
         loc_p2_ff    <= p2_in;
         loc_last_ff  <= head_job.last;
         loc_empty_ff <= head_job.empty;
      end
      if (load_out) begin
         out_x_ff     <= x_in;
         out_y_ff     <= y_in;
         out_last_ff  <= loc_last_ff;
         out_empty_ff <= loc_empty_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pfe_checker.sv =====
// Port-level checks for playfair_stream_encrypt, attached by bind.
// Depends only on the top-level ports.
`default_nettype none

module pfe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("empty response without end marker or with a letter");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata >= 8'h41 && rsp_tdata <= 8'h60)
      else $error("cipher letter out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind playfair_stream_encrypt pfe_checker u_pfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== dv/playfair_stream_encrypt_tb.sv =====
// Self-checking testbench for playfair_stream_encrypt: streams plaintext bytes
// through random handshake gaps and checks every cipher response against a
// built-in digraph predictor. Depends on pfe_pkg and the RTL top level.
`timescale 1ns / 100ps

module playfair_stream_encrypt_tb;
   import pfe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [CSR_IDX_W-1:0] ROW_ADDR [NUM_ROWS] =
      '{CSR_KEY_ROW0, CSR_KEY_ROW1, CSR_KEY_ROW2, CSR_KEY_ROW3, CSR_KEY_ROW4};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } plain_byte_type;

   typedef struct packed {
      logic [7:0] letter;
      logic       empty;
      logic       last;
   } cipher_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_addr = '0;
   logic [ROW_W-1:0]  csr_wdata = '0;

   plain_byte_type    plaintext_q[$];
   cipher_type        cipher_expected[$];
   logic [ROW_W-1:0]  key_rows [NUM_ROWS] =
      '{KEY_ROW0_RST, KEY_ROW1_RST, KEY_ROW2_RST, KEY_ROW3_RST, KEY_ROW4_RST};
   logic [LETTER_W-1:0] pend_code = '0;
   logic              pend_valid = 1'b0;
   logic              steady = 1'b0;
   int                errors = 0;
   int                cycles = 0;

   playfair_stream_encrypt dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [LETTER_W-1:0] square_at(input int row, input int col);
      return key_rows[row][LETTER_W*col +: LETTER_W];
   endfunction

   function automatic void find_cell(input logic [LETTER_W-1:0] code,
                                     output int row, output int col);
      logic [LETTER_W-1:0] key;
      logic                found;
      key = (code == CODE_J) ? CODE_I : code;
      row = 0;
      col = 0;
      found = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < 5; c++) begin
            if (!found && square_at(r, c) == key) begin
               row = r;
               col = c;
               found = 1'b1;
            end
         end
      end
   endfunction

   function automatic void push_digraph(input logic [LETTER_W-1:0] a,
                                        input logic [LETTER_W-1:0] b);
      int ra, ca, rb, cb;
      logic [LETTER_W-1:0] x, y;
      find_cell(a, ra, ca);
      find_cell(b, rb, cb);
      if (ra == rb) begin
         x = square_at(ra, (ca + 1) % 5);
         y = square_at(rb, (cb + 1) % 5);
      end else if (ca == cb) begin
         x = square_at((ra + 1) % 5, ca);
         y = square_at((rb + 1) % 5, cb);
      end else begin
         x = square_at(ra, cb);
         y = square_at(rb, ca);
      end
      cipher_expected.push_back('{ASCII_UP_A + 8'(x), 1'b0, 1'b0});
      cipher_expected.push_back('{ASCII_UP_A + 8'(y), 1'b0, 1'b0});
   endfunction

   function automatic void encipher_byte(input logic [7:0] ch, input logic last);
      logic [LETTER_W-1:0] code;
      logic                have;
      int                  start;
      cipher_type          tail;
      start = cipher_expected.size();
      code = '0;
      have = 1'b0;
      if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
         code = LETTER_W'(ch - ASCII_UP_A);
         have = 1'b1;
      end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
         code = LETTER_W'(ch - ASCII_LO_A);
         have = 1'b1;
      end
      if (have) begin
         if (!pend_valid) begin
            pend_code = code;
            pend_valid = 1'b1;
         end else if (pend_code == code) begin
            push_digraph(pend_code, CODE_X);
         end else begin
            push_digraph(pend_code, code);
            pend_valid = 1'b0;
         end
      end
      if (last) begin
         if (pend_valid) begin
            push_digraph(pend_code, CODE_X);
            pend_valid = 1'b0;
         end
         pend_code = '0;
         if (cipher_expected.size() == start) begin
            cipher_expected.push_back('{8'h00, 1'b1, 1'b1});
         end else begin
            tail = cipher_expected.pop_back();
            tail.last = 1'b1;
            cipher_expected.push_back(tail);
         end
      end
   endfunction

   always @(posedge clock) begin : drive_requests
      plain_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) encipher_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (plaintext_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
               nxt = plaintext_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.ch;
               req_tlast <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      cipher_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected: expected none, got %h/%b/%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = cipher_expected.pop_front();
               if (rsp_tdata !== want.letter || rsp_tuser !== want.empty ||
                   rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                           $time, want.letter, want.empty, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         rsp_tready <= steady || $urandom_range(99) >= 30;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("playfair_stream_encrypt regression: fail");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] ch, input logic last);
      plaintext_q.push_back('{ch, last});
   endtask

   task automatic push_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], last && i == s.len() - 1);
   endtask

   task automatic push_message(input int len);
      logic [LETTER_W-1:0] prev;
      logic [7:0]          ch;
      int                  p;
      prev = LETTER_W'($urandom_range(25));
      for (int i = 0; i < len; i++) begin
         p = $urandom_range(99);
         if (p < 12) begin
            ch = 8'($urandom_range(255));
         end else begin
            if (p >= 36) prev = LETTER_W'($urandom_range(25));
            else if (p >= 28) prev = $urandom_range(1) ? CODE_I : CODE_J;
            ch = ($urandom_range(1) ? ASCII_LO_A : ASCII_UP_A) + 8'(prev);
         end
         push_byte(ch, i == len - 1);
      end
   endtask

   // hold until every request is taken and every response has come back
   task automatic drain();
      while (plaintext_q.size() != 0 || req_tvalid || cipher_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_messages(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 12);
         push_message(len);
         sent += len;
      end
      drain();
   endtask

   task automatic load_square(input logic [ROW_W-1:0] rows [NUM_ROWS]);
      for (int i = 0; i < NUM_ROWS; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_addr <= ROW_ADDR[i];
         csr_wdata <= rows[i];
         key_rows[i] = rows[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_shuffled_square();
      logic [LETTER_W-1:0] pool[$];
      logic [LETTER_W-1:0] tmp;
      logic [ROW_W-1:0]    rows [NUM_ROWS];
      int                  j;
      for (int code = 0; code < 26; code++)
         if (LETTER_W'(code) != CODE_J) pool.push_back(LETTER_W'(code));
      for (int i = pool.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = pool[i];
         pool[i] = pool[j];
         pool[j] = tmp;
      end
      for (int r = 0; r < NUM_ROWS; r++)
         for (int c = 0; c < 5; c++) rows[r][LETTER_W*c +: LETTER_W] = pool[r*5 + c];
      load_square(rows);
   endtask

   initial begin : run_test
      logic [ROW_W-1:0] rows [NUM_ROWS];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_text("Az@[`{", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_text("LlIiJ", 1'b0);
      push_text("Xx", 1'b1);
      push_text("Q", 1'b1);
      push_text("MFUZKIDEb", 1'b1);
      drain();
      run_messages(60);

      rows = '{default: '0};
      load_square(rows);
      run_messages(40);

      rows = '{default: '1};
      load_square(rows);
      run_messages(40);

      steady = 1'b1;
      load_shuffled_square();
      run_messages(80);
      steady = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) rows[i] = ROW_W'($urandom());
      load_square(rows);
      run_messages(60);

      rows = '{KEY_ROW0_RST, KEY_ROW1_RST, KEY_ROW2_RST, KEY_ROW3_RST, KEY_ROW4_RST};
      load_square(rows);
      load_shuffled_square();
      run_messages(50);

      if (errors == 0) begin
         $display("playfair_stream_encrypt regression: pass");
      end else begin
         $display("playfair_stream_encrypt regression: fail");
      end
      $finish;
   end

endmodule
